FILE: rtl/nppc_pkg.sv
package nppc_pkg;

   localparam int COORD_FRAC_BITS_DEFAULT = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NEAR_PLANE      = 3'd0,
      CSR_TAN_HALF_FOV_X  = 3'd1,
      CSR_TAN_HALF_FOV_Y  = 3'd2,
      CSR_VIEWPORT_LEFT   = 3'd3,
      CSR_VIEWPORT_TOP    = 3'd4,
      CSR_VIEWPORT_WIDTH  = 3'd5,
      CSR_VIEWPORT_HEIGHT = 3'd6
   } csr_addr_type;

   localparam logic [30:0]        NEAR_PLANE_RESET      = 31'd655;
   localparam logic [30:0]        TAN_HALF_FOV_X_RESET  = 31'd65536;
   localparam logic [30:0]        TAN_HALF_FOV_Y_RESET  = 31'd65536;
   localparam logic signed [15:0] VIEWPORT_LEFT_RESET   = 16'sd0;
   localparam logic signed [15:0] VIEWPORT_TOP_RESET    = 16'sd0;
   localparam logic [14:0]        VIEWPORT_WIDTH_RESET  = 15'd640;
   localparam logic [14:0]        VIEWPORT_HEIGHT_RESET = 15'd480;

   // projection quotient is only resolved up to the clamp value
   localparam int PROJ_QUOT_BITS = 21;
   localparam logic [PROJ_QUOT_BITS-1:0] PROJ_QUOT_LIMIT =
      PROJ_QUOT_BITS'(1) << (PROJ_QUOT_BITS - 1);

   typedef struct packed {
      logic valid;
      logic vis;
   } tag_type;

   typedef struct packed {
      logic               visible;
      logic signed [15:0] screen_x0;
      logic signed [15:0] screen_y0;
      logic signed [15:0] screen_x1;
      logic signed [15:0] screen_y1;
   } rsp_type;

endpackage

FILE: rtl/nppc_req_if.sv
interface nppc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] start_depth;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic signed [31:0] end_depth;

   modport source (output valid, start_x, start_y, start_depth, end_x, end_y, end_depth,
                   input ready);
   modport sink   (input valid, start_x, start_y, start_depth, end_x, end_y, end_depth,
                   output ready);
endinterface

FILE: rtl/nppc_rsp_if.sv
interface nppc_rsp_if;
   logic               valid;
   logic               ready;
   logic               visible;
   logic signed [15:0] screen_x0;
   logic signed [15:0] screen_y0;
   logic signed [15:0] screen_x1;
   logic signed [15:0] screen_y1;

   modport source (output valid, visible, screen_x0, screen_y0, screen_x1, screen_y1,
                   input ready);
   modport sink   (input valid, visible, screen_x0, screen_y0, screen_x1, screen_y1,
                   output ready);
endinterface

FILE: rtl/nppc_csr_if.sv
interface nppc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [nppc_pkg::CSR_ADDR_W-1:0]     addr;
   logic [nppc_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/nppc_proj_lane.sv
module nppc_proj_lane #(
   parameter int COORD_FRAC_BITS = nppc_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                ce,
   input  nppc_pkg::tag_type   tag_in,
   input  logic                negate,
   input  logic signed [31:0]  coord,
   input  logic [30:0]         z,
   input  logic [30:0]         tan,
   input  logic [14:0]         size,
   input  logic signed [15:0]  origin,
   output nppc_pkg::tag_type   tag_out,
   output logic signed [15:0]  screen
);

   localparam int ZT_W   = 62;
   localparam int CS_W   = 47;
   localparam int BASE_W = 15 + ZT_W;
   localparam int OFF_W  = CS_W + COORD_FRAC_BITS;
   localparam int NUM_W  = ((BASE_W > OFF_W) ? BASE_W : OFF_W) + 1;
   localparam int DW     = ZT_W + 1;
   localparam int QB     = nppc_pkg::PROJ_QUOT_BITS;
   localparam int SHW    = NUM_W - QB;
   localparam int CW     = (SHW > DW) ? SHW : DW;
   localparam int SW     = QB + 2;
   localparam logic signed [SW-1:0] SMAX = SW'(32767);
   localparam logic signed [SW-1:0] SMIN = SW'(-32768);

   // stage 1: depth * tangent, |coord| * size
   nppc_pkg::tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tagr_ff;
   logic [ZT_W-1:0]   zt1_ff, zt2_ff, zt3_ff;
   logic [CS_W-1:0]   cs1_ff;
   logic              cneg1_ff, cneg2_ff, cneg3_ff, neg4_ff, negr_ff;
   logic [31:0]       cmag_in;
   logic              cneg_in;

   assign cmag_in = coord[31] ? (~coord + 32'd1) : coord;
   assign cneg_in = negate ? (!coord[31] && (coord != 32'sd0)) : coord[31];

   // stage 2/3: base = size * z * tan in two partial products
   logic [45:0]        blo2_ff, bhi2_ff;
   logic [OFF_W-1:0]   off2_ff, off3_ff;
   logic [BASE_W-1:0]  base3_ff;

   // stage 4: signed numerator magnitude
   logic [NUM_W-1:0]   num4_ff;
   logic [DW-1:0]      d4_ff;
   logic [NUM_W-1:0]   bx_in, ox_in, sum_in, d2_in, num_in;
   logic [NUM_W:0]     d1_in;
   logic               borrow_in;

   assign bx_in     = NUM_W'(base3_ff);
   assign ox_in     = NUM_W'(off3_ff);
   assign sum_in    = bx_in + ox_in;
   assign d1_in     = {1'b0, bx_in} - {1'b0, ox_in};
   assign borrow_in = d1_in[NUM_W];
   assign d2_in     = ox_in - bx_in;
   assign num_in    = !cneg3_ff ? sum_in : (borrow_in ? d2_in : d1_in[NUM_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else if (ce) begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         zt1_ff   <= z * tan;
         cs1_ff   <= cmag_in * size;
         cneg1_ff <= cneg_in;

         blo2_ff  <= zt1_ff[30:0] * size;
         bhi2_ff  <= zt1_ff[61:31] * size;
         off2_ff  <= OFF_W'(cs1_ff) << COORD_FRAC_BITS;
         zt2_ff   <= zt1_ff;
         cneg2_ff <= cneg1_ff;

         base3_ff <= BASE_W'(blo2_ff) + (BASE_W'(bhi2_ff) << 31);
         off3_ff  <= off2_ff;
         zt3_ff   <= zt2_ff;
         cneg3_ff <= cneg2_ff;

         num4_ff  <= num_in;
         neg4_ff  <= cneg3_ff && borrow_in;
         d4_ff    <= {zt3_ff, 1'b0};
      end
   end

   // stage 5 and the restoring divider, one quotient bit per stage
   logic [DW-1:0]     rem_ff  [0:QB];
   logic [QB-1:0]     q_ff    [0:QB];
   logic [QB-1:0]     lo_ff   [0:QB];
   logic [DW-1:0]     d_ff    [0:QB];
   logic              sat_ff  [0:QB];
   logic              neg_ff  [0:QB];
   nppc_pkg::tag_type tagd_ff [0:QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         tagd_ff[0] <= '0;
      end else if (ce) begin
         tagd_ff[0] <= tag4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sat_ff[0] <= CW'(num4_ff >> QB) >= CW'(d4_ff);
         rem_ff[0] <= DW'(num4_ff >> QB);
         lo_ff[0]  <= num4_ff[QB-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= d4_ff;
         neg_ff[0] <= neg4_ff;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_div
      logic [DW:0] t;
      logic        ge;

      assign t  = {rem_ff[k-1], lo_ff[k-1][QB-1]};
      assign ge = t >= {1'b0, d_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            tagd_ff[k] <= '0;
         end else if (ce) begin
            tagd_ff[k] <= tagd_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[k] <= ge ? DW'(t - {1'b0, d_ff[k-1]}) : DW'(t);
            q_ff[k]   <= {q_ff[k-1][QB-2:0], ge};
            lo_ff[k]  <= lo_ff[k-1] << 1;
            d_ff[k]   <= d_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   // rounding, clamp, viewport offset and 16-bit saturation
   logic [QB:0]           qr_in;
   logic                  rnd_in;
   logic [QB-1:0]         qv_in, qv_ff;
   logic signed [SW-1:0]  sv_in, mq_in;
   logic signed [15:0]    screen_in, screen_ff;
   nppc_pkg::tag_type     tago_ff;

   assign rnd_in = {rem_ff[QB], 1'b0} >= {1'b0, d_ff[QB]};
   assign qr_in  = (QB+1)'(q_ff[QB]) + (QB+1)'(rnd_in);
   assign qv_in  = (sat_ff[QB] || qr_in > (QB+1)'(nppc_pkg::PROJ_QUOT_LIMIT)) ?
                   nppc_pkg::PROJ_QUOT_LIMIT : qr_in[QB-1:0];

   assign mq_in  = $signed(SW'(qv_ff));
   assign sv_in  = SW'(origin) + (negr_ff ? -mq_in : mq_in);

   always_comb begin
      if (!tagr_ff.vis) begin
         screen_in = 16'sd0;
      end else if (sv_in > SMAX) begin
         screen_in = 16'sd32767;
      end else if (sv_in < SMIN) begin
         screen_in = -16'sd32768;
      end else begin
         screen_in = sv_in[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tagr_ff <= '0;
         tago_ff <= '0;
      end else if (ce) begin
         tagr_ff <= tagd_ff[QB];
         tago_ff <= tagr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         qv_ff     <= qv_in;
         negr_ff   <= neg_ff[QB];
         screen_ff <= screen_in;
      end
   end

   assign tag_out = tago_ff;
   assign screen  = screen_ff;

endmodule

FILE: rtl/near_plane_clip_project.sv
// Near-plane clip and perspective projection of camera-space line segments.
// One segment is accepted per clock while the skid entry is empty, and each
// segment passes through two pipelined restoring dividers, a
// 32-stage one for the clip fraction and a 21-stage one per endpoint
// coordinate for the projection. An output register with a skid entry lets
// the pipeline keep taking segments while a result waits. A segment with both
// depths at or before the near plane comes out with visible low and zero
// coordinates. Write the control registers only while no segment is in flight.
module near_plane_clip_project #(
   parameter int COORD_FRAC_BITS = nppc_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   nppc_req_if.sink   req_ch,
   nppc_rsp_if.source rsp_ch,
   nppc_csr_if.sink   csr_ch
);

   localparam int CQ = 32;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic               a_in;
      logic               b_in;
      logic               xneg;
      logic               yneg;
   } seg_type;

   function automatic logic signed [32:0] sx33(input logic [31:0] v);
      sx33 = $signed({v[31], v});
   endfunction

   // control registers
   logic [30:0]        near_ff, tanx_ff, tany_ff;
   logic signed [15:0] left_ff, top_ff;
   logic [14:0]        vw_ff, vh_ff;
   logic [30:0]        near_eff, tanx_eff, tany_eff;

   assign csr_ch.ready = 1'b1;
   assign near_eff = (near_ff == 31'd0) ? 31'd1 : near_ff;
   assign tanx_eff = (tanx_ff == 31'd0) ? 31'd1 : tanx_ff;
   assign tany_eff = (tany_ff == 31'd0) ? 31'd1 : tany_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= nppc_pkg::NEAR_PLANE_RESET;
         tanx_ff <= nppc_pkg::TAN_HALF_FOV_X_RESET;
         tany_ff <= nppc_pkg::TAN_HALF_FOV_Y_RESET;
         left_ff <= nppc_pkg::VIEWPORT_LEFT_RESET;
         top_ff  <= nppc_pkg::VIEWPORT_TOP_RESET;
         vw_ff   <= nppc_pkg::VIEWPORT_WIDTH_RESET;
         vh_ff   <= nppc_pkg::VIEWPORT_HEIGHT_RESET;
      end else if (csr_ch.valid) begin
         unique case (nppc_pkg::csr_addr_type'(csr_ch.addr))
            nppc_pkg::CSR_NEAR_PLANE:      near_ff <= csr_ch.data[30:0];
            nppc_pkg::CSR_TAN_HALF_FOV_X:  tanx_ff <= csr_ch.data[30:0];
            nppc_pkg::CSR_TAN_HALF_FOV_Y:  tany_ff <= csr_ch.data[30:0];
            nppc_pkg::CSR_VIEWPORT_LEFT:   left_ff <= csr_ch.data[15:0];
            nppc_pkg::CSR_VIEWPORT_TOP:    top_ff  <= csr_ch.data[15:0];
            nppc_pkg::CSR_VIEWPORT_WIDTH:  vw_ff   <= csr_ch.data[14:0];
            nppc_pkg::CSR_VIEWPORT_HEIGHT: vh_ff   <= csr_ch.data[14:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: frozen only while the skid entry is occupied
   logic ce;
   logic skid_v_ff;

   assign ce           = !skid_v_ff;
   assign req_ch.ready = ce;

   // stage 0: input register
   seg_type seg0_ff;
   logic    v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (ce) begin
         v0_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         seg0_ff.ax   <= req_ch.start_x;
         seg0_ff.ay   <= req_ch.start_y;
         seg0_ff.az   <= req_ch.start_depth;
         seg0_ff.bx   <= req_ch.end_x;
         seg0_ff.by   <= req_ch.end_y;
         seg0_ff.bz   <= req_ch.end_depth;
         seg0_ff.a_in <= 1'b0;
         seg0_ff.b_in <= 1'b0;
         seg0_ff.xneg <= 1'b0;
         seg0_ff.yneg <= 1'b0;
      end
   end

   // stage 1: plane tests, clip fraction terms, deltas
   logic signed [32:0] n33, az33, bz33, ax33, bx33, ay33, by33;
   seg_type            seg1_in, seg1_ff;
   logic [31:0]        num1_in, den1_in, adx1_in, ady1_in;
   logic [31:0]        num1_ff, den1_ff, adx1_ff, ady1_ff;
   logic               v1_ff;

   assign n33  = $signed({2'b00, near_eff});
   assign az33 = sx33(seg0_ff.az);
   assign bz33 = sx33(seg0_ff.bz);
   assign ax33 = sx33(seg0_ff.ax);
   assign bx33 = sx33(seg0_ff.bx);
   assign ay33 = sx33(seg0_ff.ay);
   assign by33 = sx33(seg0_ff.by);

   always_comb begin
      seg1_in      = seg0_ff;
      seg1_in.a_in = az33 <= n33;
      seg1_in.b_in = bz33 <= n33;
      seg1_in.xneg = bx33 < ax33;
      seg1_in.yneg = by33 < ay33;
      num1_in = seg1_in.a_in ? 32'(n33 - az33) : 32'(az33 - n33);
      den1_in = (bz33 >= az33) ? 32'(bz33 - az33) : 32'(az33 - bz33);
      adx1_in = seg1_in.xneg ? 32'(ax33 - bx33) : 32'(bx33 - ax33);
      ady1_in = seg1_in.yneg ? 32'(ay33 - by33) : 32'(by33 - ay33);
   end

   // stage 2: |delta| * (plane distance)
   seg_type     seg2_ff;
   logic [63:0] px2_ff, py2_ff;
   logic [31:0] den2_ff;
   logic        v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         seg1_ff <= seg1_in;
         num1_ff <= num1_in;
         den1_ff <= den1_in;
         adx1_ff <= adx1_in;
         ady1_ff <= ady1_in;

         seg2_ff <= seg1_ff;
         px2_ff  <= adx1_ff * num1_ff;
         py2_ff  <= ady1_ff * num1_ff;
         den2_ff <= den1_ff;
      end
   end

   // clip divider, one quotient bit per stage for x and y
   logic [31:0] remx_ff [0:CQ];
   logic [31:0] remy_ff [0:CQ];
   logic [31:0] qx_ff   [0:CQ];
   logic [31:0] qy_ff   [0:CQ];
   logic [31:0] lox_ff  [0:CQ];
   logic [31:0] loy_ff  [0:CQ];
   logic [31:0] den_ff  [0:CQ];
   seg_type     segd_ff [0:CQ];
   logic        vd_ff   [0:CQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff[0] <= 1'b0;
      end else if (ce) begin
         vd_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         remx_ff[0] <= px2_ff[63:32];
         remy_ff[0] <= py2_ff[63:32];
         lox_ff[0]  <= px2_ff[31:0];
         loy_ff[0]  <= py2_ff[31:0];
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         den_ff[0]  <= den2_ff;
         segd_ff[0] <= seg2_ff;
      end
   end

   for (genvar k = 1; k <= CQ; k++) begin : g_cdiv
      logic [32:0] tx, ty;
      logic        gex, gey;

      assign tx  = {remx_ff[k-1], lox_ff[k-1][31]};
      assign ty  = {remy_ff[k-1], loy_ff[k-1][31]};
      assign gex = tx >= {1'b0, den_ff[k-1]};
      assign gey = ty >= {1'b0, den_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else if (ce) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            remx_ff[k] <= gex ? 32'(tx - {1'b0, den_ff[k-1]}) : 32'(tx);
            remy_ff[k] <= gey ? 32'(ty - {1'b0, den_ff[k-1]}) : 32'(ty);
            qx_ff[k]   <= {qx_ff[k-1][30:0], gex};
            qy_ff[k]   <= {qy_ff[k-1][30:0], gey};
            lox_ff[k]  <= lox_ff[k-1] << 1;
            loy_ff[k]  <= loy_ff[k-1] << 1;
            den_ff[k]  <= den_ff[k-1];
            segd_ff[k] <= segd_ff[k-1];
         end
      end
   end

   // round the clip offsets
   logic        rndx_in, rndy_in;
   logic [32:0] ox_ff, oy_ff;
   seg_type     segr_ff;
   logic        vr_ff;

   assign rndx_in = {remx_ff[CQ], 1'b0} >= {1'b0, den_ff[CQ]};
   assign rndy_in = {remy_ff[CQ], 1'b0} >= {1'b0, den_ff[CQ]};

   // move the clipped endpoint onto the plane
   logic signed [33:0] cx_in, cy_in, mox_in, moy_in;
   logic               clip_a_in, clip_b_in;
   nppc_pkg::tag_type  tag_p_in, tag_p_ff;
   logic signed [31:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [30:0]        z0_ff, z1_ff;

   assign mox_in    = $signed({1'b0, ox_ff});
   assign moy_in    = $signed({1'b0, oy_ff});
   assign cx_in     = 34'(segr_ff.ax) + (segr_ff.xneg ? -mox_in : mox_in);
   assign cy_in     = 34'(segr_ff.ay) + (segr_ff.yneg ? -moy_in : moy_in);
   assign clip_a_in = segr_ff.a_in && !segr_ff.b_in;
   assign clip_b_in = segr_ff.b_in && !segr_ff.a_in;
   assign tag_p_in  = '{valid: vr_ff, vis: !(segr_ff.a_in && segr_ff.b_in)};

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff    <= 1'b0;
         tag_p_ff <= '0;
      end else if (ce) begin
         vr_ff    <= vd_ff[CQ];
         tag_p_ff <= tag_p_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ox_ff   <= 33'(qx_ff[CQ]) + 33'(rndx_in);
         oy_ff   <= 33'(qy_ff[CQ]) + 33'(rndy_in);
         segr_ff <= segd_ff[CQ];

         x0_ff <= clip_a_in ? cx_in[31:0] : segr_ff.ax;
         y0_ff <= clip_a_in ? cy_in[31:0] : segr_ff.ay;
         z0_ff <= clip_a_in ? near_eff : segr_ff.az[30:0];
         x1_ff <= clip_b_in ? cx_in[31:0] : segr_ff.bx;
         y1_ff <= clip_b_in ? cy_in[31:0] : segr_ff.by;
         z1_ff <= clip_b_in ? near_eff : segr_ff.bz[30:0];
      end
   end

   // projection lanes
   nppc_pkg::tag_type  tag_x0, tag_y0, tag_x1, tag_y1;
   logic signed [15:0] sx0, sy0, sx1, sy1;

   nppc_proj_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_x0 (
      .clock(clock), .reset(reset), .ce(ce), .tag_in(tag_p_ff), .negate(1'b0),
      .coord(x0_ff), .z(z0_ff), .tan(tanx_eff), .size(vw_ff), .origin(left_ff),
      .tag_out(tag_x0), .screen(sx0)
   );

   nppc_proj_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_y0 (
      .clock(clock), .reset(reset), .ce(ce), .tag_in(tag_p_ff), .negate(1'b1),
      .coord(y0_ff), .z(z0_ff), .tan(tany_eff), .size(vh_ff), .origin(top_ff),
      .tag_out(tag_y0), .screen(sy0)
   );

   nppc_proj_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_x1 (
      .clock(clock), .reset(reset), .ce(ce), .tag_in(tag_p_ff), .negate(1'b0),
      .coord(x1_ff), .z(z1_ff), .tan(tanx_eff), .size(vw_ff), .origin(left_ff),
      .tag_out(tag_x1), .screen(sx1)
   );

   nppc_proj_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_y1 (
      .clock(clock), .reset(reset), .ce(ce), .tag_in(tag_p_ff), .negate(1'b1),
      .coord(y1_ff), .z(z1_ff), .tan(tany_eff), .size(vh_ff), .origin(top_ff),
      .tag_out(tag_y1), .screen(sy1)
   );

   // output register with skid entry
   logic              last_v;
   nppc_pkg::rsp_type last_d;
   nppc_pkg::rsp_type out_d_ff, out_d_in, skid_d_ff, skid_d_in;
   logic              out_v_ff, out_v_in, skid_v_in;

   assign last_v = tag_x0.valid & tag_y0.valid & tag_x1.valid & tag_y1.valid;
   assign last_d = '{visible:   tag_x0.vis & tag_y0.vis & tag_x1.vis & tag_y1.vis,
                     screen_x0: sx0, screen_y0: sy0, screen_x1: sx1, screen_y1: sy1};

   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (skid_v_ff) begin
         if (rsp_ch.ready) begin
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end
      end else if (!out_v_ff || rsp_ch.ready) begin
         out_v_in = last_v;
         out_d_in = last_d;
      end else if (last_v) begin
         skid_v_in = 1'b1;
         skid_d_in = last_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.visible   = out_d_ff.visible;
   assign rsp_ch.screen_x0 = out_d_ff.screen_x0;
   assign rsp_ch.screen_y0 = out_d_ff.screen_y0;
   assign rsp_ch.screen_x1 = out_d_ff.screen_x1;
   assign rsp_ch.screen_y1 = out_d_ff.screen_y1;

endmodule

FILE: tb/sv/tb_near_plane_clip_project.sv
`timescale 1ns / 100ps

module tb_near_plane_clip_project;

   localparam logic [nppc_pkg::CSR_ADDR_W-1:0] CSR_UNUSED = 3'd7;
   localparam int FRAC = nppc_pkg::COORD_FRAC_BITS_DEFAULT;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic signed [31:0] sx, sy, sz, ex, ey, ez;
   } segment_type;

   function automatic longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic logic [127:0] div_round(logic [127:0] num, logic [127:0] den);
      logic [127:0] q, r;
      q = num / den;
      r = num % den;
      if (r >= den - r) q = q + 1;
      return q;
   endfunction

   class screen_scoreboard;
      logic [30:0]        near, tan_x, tan_y;
      logic signed [15:0] left, top;
      logic [14:0]        width, height;
      nppc_pkg::rsp_type  expected_q[$];
      int                 mismatches;

      function new();
         near = nppc_pkg::NEAR_PLANE_RESET;
         tan_x = nppc_pkg::TAN_HALF_FOV_X_RESET;
         tan_y = nppc_pkg::TAN_HALF_FOV_Y_RESET;
         left = nppc_pkg::VIEWPORT_LEFT_RESET;
         top = nppc_pkg::VIEWPORT_TOP_RESET;
         width = nppc_pkg::VIEWPORT_WIDTH_RESET;
         height = nppc_pkg::VIEWPORT_HEIGHT_RESET;
         mismatches = 0;
      endfunction

      function longint near_eff();
         return (near == 0) ? 1 : longint'(near);
      endfunction

      function void write_reg(logic [nppc_pkg::CSR_ADDR_W-1:0] idx,
                              logic [nppc_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            nppc_pkg::CSR_NEAR_PLANE:      near = data[30:0];
            nppc_pkg::CSR_TAN_HALF_FOV_X:  tan_x = data[30:0];
            nppc_pkg::CSR_TAN_HALF_FOV_Y:  tan_y = data[30:0];
            nppc_pkg::CSR_VIEWPORT_LEFT:   left = data[15:0];
            nppc_pkg::CSR_VIEWPORT_TOP:    top = data[15:0];
            nppc_pkg::CSR_VIEWPORT_WIDTH:  width = data[14:0];
            nppc_pkg::CSR_VIEWPORT_HEIGHT: height = data[14:0];
            default: ;
         endcase
      endfunction

      function logic signed [15:0] to_screen(longint coord, bit negate, longint unsigned size,
                                             longint unsigned z, longint unsigned tn,
                                             longint origin);
         logic [127:0] base, off, num, q, den;
         bit cneg, neg;
         longint qv, v;
         base = 128'(size) * 128'(z) * 128'(tn);
         off = 128'(mag(coord)) * (128'(size) << FRAC);
         cneg = (coord < 0) != negate;
         if (coord == 0) cneg = 0;
         neg = 0;
         if (!cneg) num = base + off;
         else if (base >= off) num = base - off;
         else begin
            num = off - base;
            neg = 1;
         end
         den = 128'(2) * 128'(z) * 128'(tn);
         q = div_round(num, den);
         qv = (q > 128'h100000) ? 64'h100000 : longint'(q[63:0]);
         v = origin + (neg ? -qv : qv);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return 16'(v);
      endfunction

      function longint clip_lerp(longint a, longint b, longint unsigned num,
                                 longint unsigned den);
         longint d, o;
         logic [127:0] q;
         d = b - a;
         q = div_round(128'(mag(d)) * 128'(num), 128'(den));
         o = longint'(q[63:0]);
         return a + ((d < 0) ? -o : o);
      endfunction

      function void note_segment(segment_type s);
         longint ax, ay, az, bx, by, bz, n, cx, cy;
         longint unsigned tx, ty, fnum, fden;
         bit a_in, b_in;
         nppc_pkg::rsp_type r;
         ax = s.sx; ay = s.sy; az = s.sz;
         bx = s.ex; by = s.ey; bz = s.ez;
         n = near_eff();
         tx = (tan_x == 0) ? 1 : tan_x;
         ty = (tan_y == 0) ? 1 : tan_y;
         a_in = az <= n;
         b_in = bz <= n;
         r = '0;
         if (!(a_in && b_in)) begin
            if (a_in || b_in) begin
               fnum = mag(n - az);
               fden = mag(bz - az);
               cx = clip_lerp(ax, bx, fnum, fden);
               cy = clip_lerp(ay, by, fnum, fden);
               if (a_in) begin
                  ax = cx; ay = cy; az = n;
               end else begin
                  bx = cx; by = cy; bz = n;
               end
            end
            r.visible = 1;
            r.screen_x0 = to_screen(ax, 0, width, az, tx, left);
            r.screen_y0 = to_screen(ay, 1, height, az, ty, top);
            r.screen_x1 = to_screen(bx, 0, width, bz, tx, left);
            r.screen_y1 = to_screen(by, 1, height, bz, ty, top);
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(nppc_pkg::rsp_type got);
         nppc_pkg::rsp_type exp_r;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %p", got);
            return;
         end
         exp_r = expected_q.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected vis=%0d %0d %0d %0d %0d, got vis=%0d %0d %0d %0d %0d",
                        exp_r.visible, exp_r.screen_x0, exp_r.screen_y0, exp_r.screen_x1,
                        exp_r.screen_y1, got.visible, got.screen_x0, got.screen_y0,
                        got.screen_x1, got.screen_y1);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int   src_idle_pct = 0;
   int   snk_stall_pct = 0;
   int   hold_left = 0;

   screen_scoreboard sb = new();

   nppc_req_if req_ch ();
   nppc_rsp_if rsp_ch ();
   nppc_csr_if csr_ch ();

   near_plane_clip_project uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.start_x = 0; req_ch.start_y = 0; req_ch.start_depth = 0;
      req_ch.end_x = 0; req_ch.end_y = 0; req_ch.end_depth = 0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0;
      csr_ch.addr = '0;
      csr_ch.data = '0;
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_segment('{req_ch.start_x, req_ch.start_y, req_ch.start_depth,
                              req_ch.end_x, req_ch.end_y, req_ch.end_depth});
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result('{rsp_ch.visible, rsp_ch.screen_x0, rsp_ch.screen_y0,
                              rsp_ch.screen_x1, rsp_ch.screen_y1});
         if (csr_ch.valid && csr_ch.ready)
            sb.write_reg(csr_ch.addr, csr_ch.data);
      end
   end

   task automatic send_segment(segment_type s);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.start_x <= s.sx; req_ch.start_y <= s.sy; req_ch.start_depth <= s.sz;
      req_ch.end_x <= s.ex; req_ch.end_y <= s.ey; req_ch.end_depth <= s.ez;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [nppc_pkg::CSR_ADDR_W-1:0] idx, logic [31:0] data);
      csr_ch.valid <= 1;
      csr_ch.addr <= idx;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 0;
   endtask

   // idle the input, then wait until every result is back and the pipe is empty
   task automatic drain();
      req_ch.valid <= 0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(logic [31:0] np, logic [31:0] tx, logic [31:0] ty,
                             logic [31:0] vl, logic [31:0] vt, logic [31:0] vw,
                             logic [31:0] vh);
      write_csr(nppc_pkg::CSR_NEAR_PLANE, np);
      write_csr(nppc_pkg::CSR_TAN_HALF_FOV_X, tx);
      write_csr(nppc_pkg::CSR_TAN_HALF_FOV_Y, ty);
      write_csr(nppc_pkg::CSR_VIEWPORT_LEFT, vl);
      write_csr(nppc_pkg::CSR_VIEWPORT_TOP, vt);
      write_csr(nppc_pkg::CSR_VIEWPORT_WIDTH, vw);
      write_csr(nppc_pkg::CSR_VIEWPORT_HEIGHT, vh);
   endtask

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh80000000) return 32'sh80000000;
      return 32'(v);
   endfunction

   function automatic logic signed [31:0] pick_depth(longint n);
      case ($urandom_range(9))
         0: return $urandom;
         1: return sat32(n - $urandom_range(0, 3));
         2: return sat32(n);
         3: return sat32(n - $urandom_range(0, 32'h7FFFFFF));
         4, 5: return sat32(n + $urandom_range(1, 1000));
         default: return sat32(n + $urandom_range(0, 32'h3FFFFFF));
      endcase
   endfunction

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         2: return 0;
         default: return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh1FFFFF;
      endcase
   endfunction

   task automatic random_phase(int count, bit pressure);
      segment_type s;
      longint n;
      for (int i = 0; i < count; i++) begin
         n = sb.near_eff();
         if ($urandom_range(99) < 80)
            s = '{pick_coord(), pick_coord(), pick_depth(n),
                  pick_coord(), pick_coord(), pick_depth(n)};
         else
            s = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         if (pressure && i == count / 3) begin
            req_ch.valid <= 0;
            @(posedge clock);
            hold_left = 400;
            @(negedge clock);
         end
         if (pressure && i == 2 * count / 3) begin
            req_ch.valid <= 0;
            while (sb.expected_q.size() != 0) @(negedge clock);
         end
         send_segment(s);
      end
      drain();
   endtask

   initial begin
      longint n;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed segments under reset configuration
      n = sb.near_eff();
      send_segment('{0, 0, 0, 0, 0, 0});
      send_segment('{65536, 65536, sat32(n), 0, 0, sat32(n)});
      send_segment('{65536, -65536, 32'sh80000000, 0, 0, 32'sh80000000});
      send_segment('{65536, 65536, 0, -65536, -65536, 32'sh00100000});
      send_segment('{-65536, 65536, 32'sh00100000, 65536, -65536, 0});
      send_segment('{0, 0, sat32(n), 0, 0, 32'sh00010000});
      send_segment('{0, 0, 32'sh00010000, 0, 0, sat32(n)});
      send_segment('{32'sh7FFFFFFF, 32'sh7FFFFFFF, sat32(n + 1),
                     32'sh80000000, 32'sh80000000, sat32(n + 1)});
      send_segment('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                     32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF});
      send_segment('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                     32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000});
      send_segment('{32'sh00008000, -32'sh00008000, 32'sh00020000,
                     -32'sh00008000, 32'sh00008000, 32'sh00020000});
      send_segment('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
      send_segment('{-32'sh00010000, 32'sh00030000, sat32(n - 1),
                     32'sh00050000, -32'sh00070000, sat32(n + 1)});
      drain();

      // extremes: smallest near and tangents, 16384-wide viewport one row high
      set_config(32'd0, 32'd1, 32'd0, 32'hFFFF8000, 32'h00007FFF, 32'd16384, 32'd1);
      write_csr(CSR_UNUSED, $urandom);
      src_idle_pct = 0; snk_stall_pct = 0;
      random_phase(210, 1);

      set_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00007FFF, 32'hFFFF8000,
                 32'd1, 32'd16384);
      src_idle_pct = 86; snk_stall_pct = 0;
      random_phase(200, 0);

      set_config($urandom_range(1, 32'h40000), $urandom_range(1, 32'h7FFFFFFF),
                 $urandom_range(1, 32'h7FFFFFFF), $urandom, $urandom, 32'd0, 32'd32767);
      src_idle_pct = 0; snk_stall_pct = 86;
      random_phase(200, 0);

      set_config(32'd6554, 32'd37837, 32'd28378, $urandom, $urandom,
                 $urandom_range(1, 16384), $urandom_range(1, 16384));
      src_idle_pct = 33; snk_stall_pct = 33;
      random_phase(230, 1);

      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("PASS near_plane_clip_project");
      else
         $display("FAIL near_plane_clip_project");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL near_plane_clip_project");
      $finish;
   end

endmodule

FILE: near_plane_clip_project.f
rtl/nppc_pkg.sv
rtl/nppc_req_if.sv
rtl/nppc_rsp_if.sv
rtl/nppc_csr_if.sv
rtl/nppc_proj_lane.sv
rtl/near_plane_clip_project.sv
tb/sv/tb_near_plane_clip_project.sv
